FILE: design/ssp_pkg.sv
// size suffix string parser: shared types, character codes and helper functions
// used by the top level and the suffix scaling stage; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SUFLEN_W = 2;

    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_B       = 8'h62;
    localparam logic [CHAR_W-1:0] CH_K       = 8'h6b;
    localparam logic [CHAR_W-1:0] CH_M       = 8'h6d;
    localparam logic [CHAR_W-1:0] CH_G       = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T       = 8'h74;
    localparam logic [CHAR_W-1:0] CH_P       = 8'h70;

    localparam logic [SUFLEN_W-1:0] SUFLEN_NONE = 2'd0;
    localparam logic [SUFLEN_W-1:0] SUFLEN_ONE  = 2'd1;
    localparam logic [SUFLEN_W-1:0] SUFLEN_TWO  = 2'd2;
    localparam logic [SUFLEN_W-1:0] SUFLEN_MAX  = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0]   first;
        logic [CHAR_W-1:0]   second;
        logic [SUFLEN_W-1:0] length;
    } t_suffix;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return is_upper(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [CHAR_W-1:0] lower_of(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? c + CH_CASE : c;
    endfunction

endpackage

`default_nettype wire

FILE: design/ssp_suffix_scale.sv
// size suffix string parser: decodes the stored suffix and scales the value
// by the matching power of two; depends on ssp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssp_suffix_scale (
    input  ssp_pkg::t_suffix                  i_suffix,
    input  logic [ssp_pkg::VALUE_W-1:0]       i_value,
    output logic [ssp_pkg::VALUE_W-1:0]       o_value
);
    import ssp_pkg::*;

    typedef enum logic [2:0] {
        SC_NONE,
        SC_KILO,
        SC_MEGA,
        SC_GIGA,
        SC_TERA,
        SC_PETA
    } t_scale;

    t_scale            scale;
    logic              form_ok;
    logic [CHAR_W-1:0] lo_first;
    logic [CHAR_W-1:0] lo_second;

    always_comb begin
        lo_first  = lower_of(i_suffix.first);
        lo_second = lower_of(i_suffix.second);
        form_ok   = (i_suffix.length == SUFLEN_ONE) ||
                    ((i_suffix.length == SUFLEN_TWO) && (lo_second == CH_B));
        scale     = SC_NONE;
        if (form_ok) begin
            case (lo_first)
                CH_K:    scale = SC_KILO;
                CH_M:    scale = SC_MEGA;
                CH_G:    scale = SC_GIGA;
                CH_T:    scale = SC_TERA;
                CH_P:    scale = SC_PETA;
                default: scale = SC_NONE;
            endcase
        end
    end

    always_comb begin
        case (scale)
            SC_KILO: o_value = i_value << 10;
            SC_MEGA: o_value = i_value << 20;
            SC_GIGA: o_value = i_value << 30;
            SC_TERA: o_value = i_value << 40;
            SC_PETA: o_value = i_value << 50;
            default: o_value = i_value;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/size_suffix_string_parser.sv
// size suffix string parser top level: digit accumulation, suffix capture
// and result register; depends on ssp_pkg and ssp_suffix_scale
//
//  channel | direction | ports                                   | transaction
//  in      | sink      | i_in_valid o_in_ready i_char_in         | one byte of the string
//          |           | i_last_byte                             |
//  out     | source    | o_out_valid i_out_ready o_size_bytes    | one size per string
//
// one byte per cycle while no held result stalls the input; a result appears in the cycle after the last byte is taken
// the scan state and the result register are the only storage; the 64-bit
// multiply-by-ten add and the suffix shift sit in one pass before them
// reset (synchronous, active low) clears scan state and the result valid
// a held result stalls the input only while it waits to be taken
`timescale 1ns / 1ps
`default_nettype none

module size_suffix_string_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ssp_pkg::CHAR_W-1:0]    i_char_in,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ssp_pkg::VALUE_W-1:0]   o_size_bytes
);
    import ssp_pkg::*;

    typedef enum logic [1:0] {
        PH_DIGITS = 2'd0,
        PH_GAP    = 2'd1,
        PH_SUFFIX = 2'd2
    } t_phase;

    t_phase               r_phase,  n_phase;
    logic [VALUE_W-1:0]   r_accum,  n_accum;
    logic                 r_ovf,    n_ovf;
    t_suffix              r_suffix, n_suffix;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_size;

    logic                 in_acc;
    logic [VALUE_W+3:0]   wide;
    logic [VALUE_W-1:0]   scaled;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_size_bytes = r_size;

    // value * 10 + digit, top bits flag overflow past 64 bits
    assign wide = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                + {{VALUE_W{1'b0}}, i_char_in[3:0]};

    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_ovf    = r_ovf;
        n_suffix = r_suffix;
        if (r_phase == PH_SUFFIX) begin
            if (r_suffix.length == SUFLEN_ONE) begin
                n_suffix.second = i_char_in;
            end
            if (r_suffix.length != SUFLEN_MAX) begin
                n_suffix.length = r_suffix.length + SUFLEN_ONE;
            end
        end else if (is_letter(i_char_in)) begin
            n_phase         = PH_SUFFIX;
            n_suffix.first  = i_char_in;
            n_suffix.length = SUFLEN_ONE;
        end else if ((r_phase == PH_DIGITS) && is_digit(i_char_in)) begin
            if (!r_ovf) begin
                if (wide[VALUE_W+3:VALUE_W] != 4'd0) begin
                    n_ovf = 1'b1;
                end else begin
                    n_accum = wide[VALUE_W-1:0];
                end
            end
        end else begin
            n_phase = PH_GAP;
        end
    end

    ssp_suffix_scale u_scale (
        .i_suffix (n_suffix),
        .i_value  (n_accum),
        .o_value  (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DIGITS;
            r_accum     <= '0;
            r_ovf       <= 1'b0;
            r_suffix    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                if (i_last_byte) begin
                    r_phase     <= PH_DIGITS;
                    r_accum     <= '0;
                    r_ovf       <= 1'b0;
                    r_suffix    <= '0;
                end else begin
                    r_phase  <= n_phase;
                    r_accum  <= n_accum;
                    r_ovf    <= n_ovf;
                    r_suffix <= n_suffix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_size <= n_ovf ? '0 : scaled;
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_out_valid)
        else $error("result not raised after last byte");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte && n_ovf |=> r_size == '0)
        else $error("overflowed string gave a non-zero size");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_phase == PH_DIGITS && r_accum == '0 && !r_ovf
                                  && r_suffix.length == SUFLEN_NONE)
        else $error("scan state not cleared after last byte");

    a_suffix_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SUFFIX) == (r_suffix.length != SUFLEN_NONE))
        else $error("suffix length disagrees with scan phase");

    a_no_accept_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !in_acc)
        else $error("byte taken while result held");

endmodule

`default_nettype wire
